[rtl/core/wbps_pkg.sv]
package wbps_pkg;

    localparam int PATTERN_MAX_DEF = 32;
    localparam int LEN_W           = 6;
    localparam int IDX_W           = 5;
    localparam int BYTE_W          = 8;
    localparam int ADDR_W          = 32;
    localparam int CFG_IDX_W       = 2;

    localparam logic [BYTE_W-1:0] WILDCARD = 8'hff;

    localparam logic KIND_SIG  = 1'b0;
    localparam logic KIND_DATA = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_LEN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd2;

    typedef struct packed {
        logic              sig_we;
        logic [IDX_W-1:0]  sig_index;
        logic              shift_en;
        logic [BYTE_W-1:0] byte_value;
    } row_cmd_t;

endpackage

[rtl/core/wbps_in_if.sv]
interface wbps_in_if;
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [wbps_pkg::IDX_W-1:0]   pattern_index;
    logic [wbps_pkg::BYTE_W-1:0]  byte_value;
    logic                         last_byte;

    modport source (output valid, kind, pattern_index, byte_value, last_byte, input ready);
    modport sink   (input valid, kind, pattern_index, byte_value, last_byte, output ready);
endinterface

[rtl/core/wbps_out_if.sv]
interface wbps_out_if;
    logic                         valid;
    logic                         ready;
    logic                         found;
    logic [wbps_pkg::ADDR_W-1:0]  match_address;

    modport source (output valid, found, match_address, input ready);
    modport sink   (input valid, found, match_address, output ready);
endinterface

[rtl/core/wbps_cell.sv]
module wbps_cell (
    input  logic                        clk,
    input  logic                        sig_we,
    input  logic [wbps_pkg::BYTE_W-1:0] sig_data,
    input  logic                        win_en,
    input  logic                        at_tail,
    input  logic [wbps_pkg::BYTE_W-1:0] tail_byte,
    input  logic [wbps_pkg::BYTE_W-1:0] neigh_byte,
    input  logic                        active,
    output logic [wbps_pkg::BYTE_W-1:0] win_byte,
    output logic                        hit
);
    import wbps_pkg::*;

    logic [BYTE_W-1:0] sig_reg;
    logic [BYTE_W-1:0] win_reg;
    logic [BYTE_W-1:0] win_next;

    assign win_next = at_tail ? tail_byte : neigh_byte;

    always_ff @(posedge clk)
    begin
        if (sig_we)
        begin
            sig_reg <= sig_data;
        end
        if (win_en)
        begin
            win_reg <= win_next;
        end
    end

    assign win_byte = win_reg;
    assign hit      = !active || (sig_reg == WILDCARD) || (sig_reg == win_reg);

endmodule

[rtl/core/wbps_chain.sv]
module wbps_chain #(
    parameter int PATTERN_MAX = wbps_pkg::PATTERN_MAX_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  wbps_pkg::row_cmd_t         cmd,
    input  logic                       realign_start,
    input  logic [wbps_pkg::LEN_W-1:0] len,
    input  logic [wbps_pkg::LEN_W-1:0] len_m1,
    output logic                       busy,
    output logic                       all_hit
);
    import wbps_pkg::*;

    localparam int SW_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    logic [BYTE_W-1:0]      age_reg  [PATTERN_MAX];
    logic [BYTE_W-1:0]      age_next [PATTERN_MAX];
    logic [BYTE_W-1:0]      win      [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] tail;
    logic [PATTERN_MAX-1:0] active;
    logic [PATTERN_MAX-1:0] sig_sel;
    logic [PATTERN_MAX-1:0] hit;
    logic [BYTE_W-1:0]      tap;
    logic [BYTE_W-1:0]      tail_byte;
    logic                   win_en;
    logic                   fill_en;
    logic                   sweep_end;
    logic                   busy_reg;
    logic                   again_reg;
    logic [SW_W-1:0]        sweep_reg;

    always_comb
    begin
        tap = '0;
        for (int k = 0; k < PATTERN_MAX; k++)
        begin
            tail[k]    = ({{(32-LEN_W){1'b0}}, len_m1} == 32'(k));
            active[k]  = (32'(k) < {{(32-LEN_W){1'b0}}, len});
            sig_sel[k] = cmd.sig_we && ({{(32-IDX_W){1'b0}}, cmd.sig_index} == 32'(k));
            if (tail[k])
            begin
                tap = tap | age_reg[k];
            end
        end
    end

    assign fill_en   = busy_reg &&
                       ({{(32-SW_W){1'b0}}, sweep_reg} < {{(32-LEN_W){1'b0}}, len});
    assign win_en    = busy_reg ? fill_en : cmd.shift_en;
    assign tail_byte = busy_reg ? tap : cmd.byte_value;
    assign sweep_end = busy_reg && (sweep_reg == SW_W'(PATTERN_MAX - 1));

    // age line: newest at entry 0; rotate during a realign sweep
    always_comb
    begin
        for (int k = 0; k < PATTERN_MAX; k++)
        begin
            if (k == 0)
            begin
                age_next[k] = busy_reg ? age_reg[PATTERN_MAX-1] : cmd.byte_value;
            end
            else
            begin
                age_next[k] = age_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg || cmd.shift_en)
        begin
            for (int k = 0; k < PATTERN_MAX; k++)
            begin
                age_reg[k] <= age_next[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            again_reg <= 1'b0;
            sweep_reg <= '0;
        end
        else if (!busy_reg)
        begin
            if (realign_start)
            begin
                busy_reg  <= 1'b1;
                sweep_reg <= '0;
            end
        end
        else if (sweep_end)
        begin
            sweep_reg <= '0;
            again_reg <= 1'b0;
            if (!(again_reg || realign_start))
            begin
                busy_reg <= 1'b0;
            end
        end
        else
        begin
            sweep_reg <= sweep_reg + 1'b1;
            if (realign_start)
            begin
                again_reg <= 1'b1;
            end
        end
    end

    for (genvar k = 0; k < PATTERN_MAX; k++)
    begin : g_cell
        logic [BYTE_W-1:0] neigh;
        if (k == PATTERN_MAX - 1)
        begin : g_end
            assign neigh = '0;
        end
        else
        begin : g_mid
            assign neigh = win[k+1];
        end

        wbps_cell u_cell (
            .clk        (clk),
            .sig_we     (sig_sel[k]),
            .sig_data   (cmd.byte_value),
            .win_en     (win_en),
            .at_tail    (tail[k]),
            .tail_byte  (tail_byte),
            .neigh_byte (neigh),
            .active     (active[k]),
            .win_byte   (win[k]),
            .hit        (hit[k])
        );
    end

    assign busy    = busy_reg;
    assign all_hit = &hit;

endmodule

[rtl/core/wildcard_byte_pattern_scan_core.sv]
// Wildcard byte signature scanner.
// item_in carries signature writes (kind 0, stored at pattern_index) and data
// bytes (kind 1, last_byte closes the region). result_out carries found and
// match_address: the first match once per arming, or not found on a region's
// last byte. Registers are written through cfg_we/cfg_index/cfg_data.
// Throughput: one item per cycle while item_in.ready is not held low by a
// realign sweep or a stalled result. A result is registered through a row
// of PATTERN_MAX compare cells, one pending stage and the output register.
// A pattern_length write starts a realign sweep that reloads the compare
// row from the byte history; item_in.ready stays low during it (a second
// length write in the sweep adds one more sweep).
// Reset clears the byte count, the report flag and the registers (length 1,
// base and offset 0); signature bytes hold garbage until written.
// When result_out stalls, a pending item that makes a result holds and
// item_in.ready drops; items that make no result keep flowing.
module wildcard_byte_pattern_scan_core #(
    parameter int PATTERN_MAX = wbps_pkg::PATTERN_MAX_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    wbps_in_if.sink                         item_in,
    wbps_out_if.source                      result_out,
    input  logic                            cfg_we,
    input  logic [wbps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wbps_pkg::ADDR_W-1:0]     cfg_data
);
    import wbps_pkg::*;

    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  len_m1_reg;
    logic              len_ok_reg;
    logic [ADDR_W-1:0] base_reg;
    logic [ADDR_W-1:0] offset_reg;
    logic [ADDR_W-1:0] bo_reg;
    logic [ADDR_W-1:0] bytes_seen_reg;
    logic [ADDR_W-1:0] bytes_seen_next;
    logic              match_reported_reg;
    logic              pend_valid_reg;
    logic              pend_last_reg;
    logic              pend_ge_reg;
    logic [ADDR_W-1:0] pend_start_reg;
    logic              out_valid_reg;
    logic              found_reg;
    logic [ADDR_W-1:0] addr_reg;

    logic              busy;
    logic              all_hit;
    logic              realign_start;
    logic              in_acc;
    logic              acc_data;
    logic              acc_sig;
    logic              sat;
    logic              ge_next;
    logic [ADDR_W-1:0] start_next;
    logic              match_hit;
    logic              pend_result;
    logic              out_free;
    logic              pend_move;
    row_cmd_t          cmd;
    logic [LEN_W-1:0]  cfg_len;

    assign out_free    = !out_valid_reg || result_out.ready;
    assign match_hit   = len_ok_reg && pend_ge_reg && all_hit;
    assign pend_result = pend_valid_reg && !match_reported_reg && (match_hit || pend_last_reg);
    assign pend_move   = !pend_result || out_free;

    assign item_in.ready = !busy && pend_move;
    assign in_acc        = item_in.valid && item_in.ready;
    assign acc_data      = in_acc && (item_in.kind == KIND_DATA);
    assign acc_sig       = in_acc && (item_in.kind == KIND_SIG);

    assign cfg_len       = cfg_data[LEN_W-1:0];
    assign realign_start = cfg_we && (cfg_index == CFG_LEN);

    assign cmd.sig_we     = acc_sig;
    assign cmd.sig_index  = item_in.pattern_index;
    assign cmd.shift_en   = acc_data;
    assign cmd.byte_value = item_in.byte_value;

    // match start and length check, computed against the count before increment
    assign sat        = &bytes_seen_reg;
    assign ge_next    = sat ||
                        (bytes_seen_reg >= {{(ADDR_W-LEN_W){1'b0}}, len_m1_reg});
    assign start_next = sat ? (bytes_seen_reg - {{(ADDR_W-LEN_W){1'b0}}, len_reg})
                            : (bytes_seen_reg - {{(ADDR_W-LEN_W){1'b0}}, len_m1_reg});
    assign bytes_seen_next = item_in.last_byte ? '0
                           : (sat ? bytes_seen_reg : bytes_seen_reg + 1'b1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg    <= LEN_W'(1);
            len_m1_reg <= '0;
            len_ok_reg <= 1'b1;
            base_reg   <= '0;
            offset_reg <= '0;
            bo_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LEN:
                begin
                    len_reg    <= cfg_len;
                    len_m1_reg <= cfg_len - 1'b1;
                    len_ok_reg <= (cfg_len != '0) &&
                                  ({{(32-LEN_W){1'b0}}, cfg_len} <= 32'(PATTERN_MAX));
                end
                CFG_BASE:
                begin
                    base_reg <= cfg_data;
                    bo_reg   <= cfg_data + offset_reg;
                end
                CFG_OFFSET:
                begin
                    offset_reg <= cfg_data;
                    bo_reg     <= base_reg + cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_seen_reg     <= '0;
            match_reported_reg <= 1'b0;
            pend_valid_reg     <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (acc_data)
            begin
                bytes_seen_reg <= bytes_seen_next;
            end

            if (acc_sig)
            begin
                match_reported_reg <= 1'b0;
            end
            else if (pend_result && out_free && match_hit)
            begin
                match_reported_reg <= 1'b1;
            end

            if (pend_move)
            begin
                pend_valid_reg <= acc_data;
            end

            if (pend_result && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_data)
        begin
            pend_last_reg  <= item_in.last_byte;
            pend_ge_reg    <= ge_next;
            pend_start_reg <= start_next;
        end
        if (pend_result && out_free)
        begin
            found_reg <= match_hit;
            addr_reg  <= match_hit ? (bo_reg + pend_start_reg) : '0;
        end
    end

    wbps_chain #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_chain (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .realign_start (realign_start),
        .len           (len_reg),
        .len_m1        (len_m1_reg),
        .busy          (busy),
        .all_hit       (all_hit)
    );

    assign result_out.valid         = out_valid_reg;
    assign result_out.found         = found_reg;
    assign result_out.match_address = addr_reg;

    a_sig_rearms: assert property (@(posedge clk) disable iff (!rst_n)
        acc_sig |=> !match_reported_reg)
        else $error("signature write did not rearm reporting");

    a_no_item_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !in_acc)
        else $error("item accepted during realign sweep");

    a_pend_holds: assert property (@(posedge clk) disable iff (!rst_n)
        pend_result && !out_free |=> pend_valid_reg && $stable(pend_start_reg))
        else $error("pending result lost while output stalled");

    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !found_reg |-> addr_reg == '0)
        else $error("not-found result carries an address");

    a_one_report: assert property (@(posedge clk) disable iff (!rst_n)
        match_reported_reg && !acc_sig |=> !(pend_result && match_hit))
        else $error("second match reported without rearm");

endmodule

[tb/sv/testbench.sv]
module testbench;
    import wbps_pkg::*;

    localparam int SIG_DEPTH    = PATTERN_MAX_DEF;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE       = 8;
    localparam int NUM_PHASES   = 12;
    localparam int PHASE_ITEMS  = 150;
    localparam int HOLD_CYCLES  = 300;
    localparam int MAX_PRINTS   = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] addr;
    } scan_report_t;

    class signature_scan_checker;
        bit [BYTE_W-1:0] signature_bytes [SIG_DEPTH];
        bit [BYTE_W-1:0] window_bytes [SIG_DEPTH];
        bit [31:0]       bytes_in_region;
        bit              report_done;
        bit [LEN_W-1:0]  sig_len;
        bit [ADDR_W-1:0] base_addr;
        bit [ADDR_W-1:0] addr_offset;
        scan_report_t    expected_reports [$];
        int              mismatches;
        int              sig_writes;
        int              data_bytes;
        int              found_reports;
        int              empty_reports;

        function new();
            int i;
            for (i = 0; i < SIG_DEPTH; i++)
            begin
                signature_bytes[i] = '0;
                window_bytes[i] = '0;
            end
            bytes_in_region = '0;
            report_done = 1'b0;
            sig_len = 6'd1;
            base_addr = '0;
            addr_offset = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] value);
            case (idx)
                CFG_LEN:    sig_len = value[LEN_W-1:0];
                CFG_BASE:   base_addr = value;
                CFG_OFFSET: addr_offset = value;
                default:    ;
            endcase
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction

        function bit window_hit();
            int j;
            bit [BYTE_W-1:0] pat;
            if (sig_len == 0 || sig_len > SIG_DEPTH || bytes_in_region < 32'(sig_len))
                return 1'b0;
            for (j = 0; j < int'(sig_len); j++)
            begin
                pat = signature_bytes[j];
                if (pat != WILDCARD && pat != window_bytes[int'(sig_len) - 1 - j])
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        function void note_item(logic kind, logic [IDX_W-1:0] idx, logic [BYTE_W-1:0] value,
                                logic last);
            int k;
            bit [31:0] start;
            scan_report_t rep;
            if (kind == KIND_SIG)
            begin
                signature_bytes[idx] = value;
                report_done = 1'b0;
                sig_writes++;
                return;
            end
            data_bytes++;
            for (k = SIG_DEPTH - 1; k > 0; k--)
                window_bytes[k] = window_bytes[k-1];
            window_bytes[0] = value;
            if (bytes_in_region != 32'hffff_ffff)
                bytes_in_region++;
            if (!report_done)
            begin
                if (window_hit())
                begin
                    start = bytes_in_region - 32'(sig_len);
                    rep.found = 1'b1;
                    rep.addr = base_addr + start + addr_offset;
                    expected_reports.push_back(rep);
                    report_done = 1'b1;
                end
                else if (last)
                begin
                    rep.found = 1'b0;
                    rep.addr = '0;
                    expected_reports.push_back(rep);
                end
            end
            if (last)
            begin
                bytes_in_region = '0;
                for (k = 0; k < SIG_DEPTH; k++)
                    window_bytes[k] = '0;
            end
        endfunction

        task report_mismatch(string msg);
            if (mismatches < MAX_PRINTS)
                $display("MISMATCH: %s", msg);
            mismatches++;
        endtask

        task check_report(logic found, logic [ADDR_W-1:0] addr);
            scan_report_t exp_rep;
            if (expected_reports.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result found=%0b addr=%08h", found, addr));
                return;
            end
            exp_rep = expected_reports.pop_front();
            if (found !== exp_rep.found)
                report_mismatch($sformatf("found %0b, want %0b", found, exp_rep.found));
            if (addr !== exp_rep.addr)
                report_mismatch($sformatf("match_address %08h, want %08h", addr, exp_rep.addr));
            if (exp_rep.found)
                found_reports++;
            else
                empty_reports++;
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ADDR_W-1:0]    cfg_data;

    wbps_in_if  item_in();
    wbps_out_if result_out();

    signature_scan_checker sb;

    int items_sent;
    int src_idle_pct;
    int sink_stall_pct;
    int hold_left;
    int active_len;
    int cycles;
    int phase_lens [NUM_PHASES] = '{1, 2, 32, 3, 0, 5, 63, 4, 8, 33, 16, 1};

    wildcard_byte_pattern_scan_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_in),
        .result_out (result_out),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_in.valid && item_in.ready)
                sb.note_item(item_in.kind, item_in.pattern_index, item_in.byte_value,
                             item_in.last_byte);
            if (result_out.valid && result_out.ready)
                sb.check_report(result_out.found, result_out.match_address);
        end
    end

    initial
    begin
        result_out.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                result_out.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                result_out.ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    task automatic send_item(input logic kind, input logic [IDX_W-1:0] idx,
                             input logic [BYTE_W-1:0] value, input logic last);
        if ($urandom_range(99) < src_idle_pct)
        begin
            item_in.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < src_idle_pct)
                @(posedge clk);
        end
        item_in.valid         <= 1'b1;
        item_in.kind          <= kind;
        item_in.pattern_index <= idx;
        item_in.byte_value    <= value;
        item_in.last_byte     <= last;
        @(negedge clk);
        while (!item_in.ready)
            @(negedge clk);
        @(posedge clk);
        items_sent++;
    endtask

    task automatic send_sig(input int idx, input logic [BYTE_W-1:0] value);
        send_item(KIND_SIG, IDX_W'(idx), value, 1'($urandom_range(1)));
    endtask

    task automatic send_data(input logic [BYTE_W-1:0] value, input logic last);
        send_item(KIND_DATA, IDX_W'($urandom_range(31)), value, last);
    endtask

    task automatic drain();
        item_in.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        sb.write_reg(idx, value);
        @(posedge clk);
    endtask

    task automatic configure(input int len, input logic [ADDR_W-1:0] base,
                             input logic [ADDR_W-1:0] offset);
        logic [ADDR_W-1:0] len_word;
        len_word = (ADDR_W'($urandom()) & ~ADDR_W'(6'h3f)) | ADDR_W'(len[LEN_W-1:0]);
        write_reg(CFG_LEN, len_word);
        write_reg(CFG_BASE, base);
        write_reg(CFG_OFFSET, offset);
        write_reg(CFG_UNUSED, ADDR_W'($urandom()));
        cfg_we <= 1'b0;
        @(posedge clk);
        active_len = len;
    endtask

    task automatic run_scan_job(input int len_cfg);
        int                sig_len;
        int                n;
        int                plant_at;
        int                i;
        logic [BYTE_W-1:0] pat [SIG_DEPTH];
        logic [BYTE_W-1:0] value;
        sig_len = (len_cfg >= 1 && len_cfg <= SIG_DEPTH) ? len_cfg : $urandom_range(1, 6);
        for (i = 0; i < sig_len; i++)
            pat[i] = ($urandom_range(3) == 0) ? WILDCARD : BYTE_W'($urandom_range(255));
        if ($urandom_range(99) < 85)
        begin
            for (i = 0; i < sig_len; i++)
                send_sig(i, pat[i]);
        end
        case ($urandom_range(9))
            0, 1:    n = $urandom_range(1, sig_len);
            2:       n = $urandom_range(1, 40);
            default: n = sig_len + $urandom_range(0, 10);
        endcase
        plant_at = (n >= sig_len && $urandom_range(99) < 70) ? $urandom_range(0, n - sig_len) : -1;
        for (i = 0; i < n; i++)
        begin
            if (plant_at >= 0 && i >= plant_at && i < plant_at + sig_len
                && pat[i-plant_at] != WILDCARD)
                value = pat[i-plant_at];
            else if ($urandom_range(1) == 1)
                value = pat[$urandom_range(0, sig_len - 1)];
            else
                value = BYTE_W'($urandom_range(255));
            if ($urandom_range(99) < 4)
                send_sig($urandom_range(31), BYTE_W'($urandom_range(255)));
            send_data(value, i == n - 1);
        end
    endtask

    task automatic set_idle_mode(input int mode);
        case (mode)
            0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            1:       begin src_idle_pct = 53; sink_stall_pct = 0;  end
            2:       begin src_idle_pct = 0;  sink_stall_pct = 53; end
            default: begin src_idle_pct = 36; sink_stall_pct = 36; end
        endcase
    endtask

    initial
    begin
        int                ph;
        int                i;
        int                phase_start;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] offset;

        sb = new();
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = '0;
        cfg_data              = '0;
        item_in.valid         = 1'b0;
        item_in.kind          = KIND_SIG;
        item_in.pattern_index = '0;
        item_in.byte_value    = '0;
        item_in.last_byte     = 1'b0;
        items_sent            = 0;
        hold_left             = 0;
        active_len            = 1;
        set_idle_mode(0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // load every signature position so no compare sees an unwritten byte
        for (i = 0; i < SIG_DEPTH; i++)
            send_sig(i, (i == 0) ? 8'h00 : (i == SIG_DEPTH - 1) ? WILDCARD
                                         : BYTE_W'($urandom_range(255)));
        drain();

        configure(1, '0, '0);
        send_data(8'h00, 1'b0);
        send_data(8'h00, 1'b1);
        send_data(8'hff, 1'b1);
        send_sig(0, WILDCARD);
        send_data(8'hff, 1'b0);
        send_sig(SIG_DEPTH - 1, 8'hfe);
        send_data(8'h5a, 1'b1);
        drain();

        configure(2, 32'hffff_ffff, 32'hffff_ffff);
        send_sig(1, 8'h12);
        send_sig(0, WILDCARD);
        send_data(8'h12, 1'b1);
        send_data(8'h34, 1'b0);
        send_data(8'h12, 1'b0);
        send_data(8'h12, 1'b1);
        drain();

        configure(0, 32'h8000_0000, 32'h7fff_ffff);
        send_sig(0, WILDCARD);
        send_data(8'h00, 1'b0);
        send_data(8'hff, 1'b1);
        drain();

        configure(63, 32'h0000_0001, 32'hffff_fffe);
        send_sig(0, WILDCARD);
        send_data(8'h01, 1'b0);
        send_data(8'h80, 1'b1);

        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            drain();
            set_idle_mode(ph % 4);
            case (ph % 3)
                0:       begin base = '0;           offset = '0;           end
                1:       begin base = 32'hffff_ffff; offset = 32'hffff_ffff; end
                default: begin base = $urandom();    offset = $urandom();    end
            endcase
            configure(phase_lens[ph], base, offset);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
                run_scan_job(active_len);
        end

        // fill the block while the result side holds off
        drain();
        set_idle_mode(0);
        configure(1, $urandom(), $urandom());
        hold_left = HOLD_CYCLES;
        for (i = 0; i < 40; i++)
        begin
            send_sig(0, WILDCARD);
            send_data(BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
        end
        drain();

        $display("Sent %0d items: %0d signature writes, %0d data bytes",
                 items_sent, sb.sig_writes, sb.data_bytes);
        $display("Checked %0d matches and %0d regions with no match, %0d mismatches",
                 sb.found_reports, sb.empty_reports, sb.mismatches);
        if (sb.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
